FILE: sv/swma_pkg.sv
// ----------------------------------------------------------------------------
// swma_pkg
// Shared types and constants for the sliding window minimum accumulator.
// ----------------------------------------------------------------------------
package swma_pkg;

  localparam int PRICE_W        = 31;
  localparam int TOTAL_W        = 63;
  localparam int CFG_W          = 7;
  localparam int WINDOW_MAX_DEF = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               start_req;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] window_min;
    logic [TOTAL_W-1:0] running_total;
  } out_item_t;

  // Running minimum handed from one cell to the next.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] min_val;
  } cell_link_t;

endpackage

FILE: sv/swma_cell.sv
// ----------------------------------------------------------------------------
// swma_cell
// One cell of the minimum chain: holds the minimum over the newest samples
// up to its position and passes it to the next cell on each accepted item.
// ----------------------------------------------------------------------------
module swma_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                clr,
  input  logic [swma_pkg::PRICE_W-1:0]        price,
  input  swma_pkg::cell_link_t                link_in,
  input  logic                                sel,
  output swma_pkg::cell_link_t                link_out,
  output swma_pkg::cell_link_t                tap_out
);

  logic                         valid_r;
  logic [swma_pkg::PRICE_W-1:0] min_r;
  logic [swma_pkg::PRICE_W-1:0] min_nxt;

  always_comb begin
    if (link_in.valid && !clr && (link_in.min_val < price)) begin
      min_nxt = link_in.min_val;
    end else begin
      min_nxt = price;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      min_r <= min_nxt;
    end
  end

  assign link_out.valid   = valid_r;
  assign link_out.min_val = min_r;
  assign tap_out.valid    = sel & valid_r;
  assign tap_out.min_val  = sel ? min_r : '0;

endmodule

FILE: sv/swma_acc.sv
// ----------------------------------------------------------------------------
// swma_acc
// Saturating running total of the window minimums.
// ----------------------------------------------------------------------------
module swma_acc (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         clr,
  input  logic [swma_pkg::PRICE_W-1:0] addend,
  output logic [swma_pkg::TOTAL_W-1:0] total_nxt
);

  logic [swma_pkg::TOTAL_W-1:0] total_r;
  logic [swma_pkg::TOTAL_W-1:0] base;
  logic [swma_pkg::TOTAL_W:0]   sum;

  always_comb begin
    base = clr ? '0 : total_r;
    sum  = {1'b0, base} + (swma_pkg::TOTAL_W + 1)'(addend);
    if (sum[swma_pkg::TOTAL_W]) begin
      total_nxt = swma_pkg::TOTAL_MAX;
    end else begin
      total_nxt = sum[swma_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (adv) begin
      total_r <= total_nxt;
    end
  end

endmodule

FILE: sv/swma_obuf.sv
// ----------------------------------------------------------------------------
// swma_obuf
// Output register with one skid entry; stall toward the source is registered.
// ----------------------------------------------------------------------------
module swma_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swma_pkg::out_item_t din,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output swma_pkg::out_item_t out_item
);

  logic                main_vld_r, main_vld_nxt;
  logic                skid_vld_r, skid_vld_nxt;
  swma_pkg::out_item_t main_r, main_nxt;
  swma_pkg::out_item_t skid_r, skid_nxt;
  logic                take;

  always_comb begin
    take         = main_vld_r && !out_stall;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || take) begin
        main_nxt     = din;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = din;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_item  = main_r;

endmodule

FILE: sv/sliding_window_min_accumulator.sv
// ----------------------------------------------------------------------------
// sliding_window_min_accumulator
// Sliding window minimum over a price stream with a saturating total.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_item): one price sample per item;
// start_req empties the window and clears the total before the sample.
// Result channel (out_valid/out_stall/out_item): one result per item, the
// minimum of the newest window_length samples and the saturating sum of all
// minimums since the last start.
// cfg_wr_en/cfg_wr_data write window_length; zero acts as 1 and values above
// WINDOW_MAX act as WINDOW_MAX. Write only while the block is idle.
// Throughput: one item per cycle while in_stall is low. Each cell of the chain
// compares its neighbor's minimum with the new sample once per item, and the
// total takes one saturating add per item.
// Result path: each result is registered in the output register or the skid entry.
// Reset: window empty, total zero, window_length 1, no result pending.
// Receiver stall: the output register holds, one more result goes into the
// skid entry, then in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module sliding_window_min_accumulator #(
  parameter int WINDOW_MAX = swma_pkg::WINDOW_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  swma_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output swma_pkg::out_item_t        out_item,
  input  logic                       cfg_wr_en,
  input  logic [swma_pkg::CFG_W-1:0] cfg_wr_data
);

  localparam int WIN_W = $clog2(WINDOW_MAX + 2);

  logic [WIN_W-1:0]             win_r, win_nxt;
  logic                         accept;
  logic                         full;
  swma_pkg::cell_link_t         link [WINDOW_MAX+1];
  swma_pkg::cell_link_t         tap  [WINDOW_MAX];
  swma_pkg::cell_link_t         tap_any;
  logic [swma_pkg::PRICE_W-1:0] best;
  logic [swma_pkg::TOTAL_W-1:0] total_nxt;
  swma_pkg::out_item_t          result;

  always_comb begin
    if (cfg_wr_data == '0) begin
      win_nxt = WIN_W'(1);
    end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
      win_nxt = WIN_W'(WINDOW_MAX);
    end else begin
      win_nxt = WIN_W'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_W'(1);
    end else if (cfg_wr_en) begin
      win_r <= win_nxt;
    end
  end

  assign accept   = in_valid && !full;
  assign in_stall = full;
  assign link[0]  = '0;

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    swma_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (accept),
      .clr      (in_item.start_req),
      .price    (in_item.price),
      .link_in  (link[j]),
      .sel      (int'(win_r) == j + 2),
      .link_out (link[j+1]),
      .tap_out  (tap[j])
    );
  end

  always_comb begin
    tap_any = '0;
    for (int j = 0; j < WINDOW_MAX; j++) begin
      tap_any = tap_any | tap[j];
    end
  end

  always_comb begin
    if (tap_any.valid && !in_item.start_req && (tap_any.min_val < in_item.price)) begin
      best = tap_any.min_val;
    end else begin
      best = in_item.price;
    end
  end

  swma_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (accept),
    .clr       (in_item.start_req),
    .addend    (best),
    .total_nxt (total_nxt)
  );

  assign result.window_min    = best;
  assign result.running_total = total_nxt;

  swma_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .din       (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

FILE: sv/swma_chk.sv
// ----------------------------------------------------------------------------
// swma_chk
// Port-level checks for the sliding window minimum accumulator.
// ----------------------------------------------------------------------------
module swma_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input swma_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input swma_pkg::out_item_t out_item
);

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && !in_stall))
    else $error("result pending right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_total_covers_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({32'd0, out_item.window_min} <= out_item.running_total))
    else $error("total below current minimum");

  a_start_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid && in_item.start_req) |=>
      (out_valid && (out_item.window_min == $past(in_item.price)) &&
       (out_item.running_total == {32'd0, $past(in_item.price)})))
    else $error("start item result wrong");

endmodule

bind sliding_window_min_accumulator swma_chk u_swma_chk (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window minimum accumulator.
// ----------------------------------------------------------------------------
// Streams price samples through the block and predicts each window minimum
// and saturating total. A short directed run covers the edge prices and the
// window settings zero, one, oversized and a mid-stream resize. Random
// segments follow, each after a window write while the block is idle, under
// three idle mixes. The first and third mixes also include a long output hold-off.
// ----------------------------------------------------------------------------
import swma_pkg::*;

class swma_scoreboard;
  logic [PRICE_W-1:0] cell_price [WINDOW_MAX_DEF];
  bit                 cell_live  [WINDOW_MAX_DEF];
  int unsigned        cell_age   [WINDOW_MAX_DEF];
  logic [TOTAL_W-1:0] min_sum;
  logic [CFG_W-1:0]   win_len;
  out_item_t          min_total_q [$];
  int                 errors;
  int                 checked;

  function new();
    for (int i = 0; i < WINDOW_MAX_DEF; i++) begin
      cell_live[i] = 1'b0;
      cell_age[i]  = 0;
    end
    min_sum = '0;
    win_len = 7'd1;
    errors  = 0;
    checked = 0;
  endfunction

  function void set_window(logic [CFG_W-1:0] v);
    win_len = v;
  endfunction

  function int pending();
    return min_total_q.size();
  endfunction

  function void note_sample(in_item_t s);
    int unsigned        span;
    logic [PRICE_W-1:0] best;
    out_item_t          e;
    span = (win_len == 0) ? 1 : (win_len > WINDOW_MAX_DEF) ? WINDOW_MAX_DEF : win_len;
    if (s.start_req) begin
      for (int i = 0; i < WINDOW_MAX_DEF; i++) begin
        cell_live[i] = 1'b0;
        cell_age[i]  = 0;
      end
      min_sum = '0;
    end
    for (int i = WINDOW_MAX_DEF - 1; i > 0; i--) begin
      cell_price[i] = cell_price[i-1];
      cell_live[i]  = cell_live[i-1];
      cell_age[i]   = cell_age[i-1] + 1;
    end
    cell_price[0] = s.price;
    cell_live[0]  = 1'b1;
    cell_age[0]   = 0;
    best = s.price;
    for (int i = 1; i < WINDOW_MAX_DEF; i++) begin
      if (cell_live[i] && cell_age[i] < span && cell_price[i] < best) best = cell_price[i];
    end
    if (min_sum > TOTAL_MAX - TOTAL_W'(best)) min_sum = TOTAL_MAX;
    else min_sum = min_sum + TOTAL_W'(best);
    e.window_min    = best;
    e.running_total = min_sum;
    min_total_q.push_back(e);
  endfunction

  task report(string what, longint unsigned got, longint unsigned want);
    errors++;
    if (errors <= 100) $display("MISMATCH %s: got %0d, want %0d", what, got, want);
  endtask

  task check_result(out_item_t got);
    out_item_t want;
    if (min_total_q.size() == 0) begin
      report("unexpected result, window_min", got.window_min, 0);
    end else begin
      want = min_total_q.pop_front();
      checked++;
      if (got.window_min !== want.window_min)
        report("window_min", got.window_min, want.window_min);
      if (got.running_total !== want.running_total)
        report("running_total", got.running_total, want.running_total);
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [PRICE_W-1:0] PRICE_TOP = '1;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  swma_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;
  int cycles        = 0;
  int samples_sent  = 0;
  int window_writes = 0;

  sliding_window_min_accumulator #(
    .WINDOW_MAX (WINDOW_MAX_DEF)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycles, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      if (hold_len > 0) begin
        hold_left = hold_len;
        hold_len  = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (in_stall);
    sb.note_sample(s);
    samples_sent++;
  endtask

  task automatic send_price(logic [PRICE_W-1:0] p, logic st);
    in_item_t s;
    s.price     = p;
    s.start_req = st;
    send_item(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_window(v);
    window_writes++;
  endtask

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(9))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'd65;
      5:       return 7'd2;
      default: return CFG_W'($urandom_range(127));
    endcase
  endfunction

  function automatic in_item_t rand_sample(bit seg_first);
    in_item_t s;
    case ($urandom_range(9))
      0:       s.price = PRICE_TOP;
      1:       s.price = PRICE_W'($urandom_range(15));
      2, 3:    s.price = PRICE_W'($urandom_range(5000));
      default: s.price = PRICE_W'($urandom());
    endcase
    s.start_req = seg_first ? ($urandom_range(9) < 7) : ($urandom_range(49) == 0);
    return s;
  endfunction

  task automatic run_phase(int n_items, int sp, int rp, bit with_hold);
    int sent;
    int seg;
    int len;
    sent = 0;
    seg  = 0;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    while (sent < n_items) begin
      write_window(pick_window());
      if (with_hold && seg == 3) hold_len = 250;
      len = $urandom_range(80, 5);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_item(rand_sample(k == 0));
        sent++;
      end
      seg++;
    end
    drain();
  endtask

  initial begin : main
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_price('0, 1'b1);
    send_price(PRICE_TOP, 1'b0);
    send_price(31'd123, 1'b0);
    write_window(7'd64);
    send_price(PRICE_TOP, 1'b1);
    send_price(31'd1000, 1'b0);
    send_price(31'd2000, 1'b0);
    send_price(PRICE_TOP, 1'b0);
    send_price('0, 1'b0);
    send_price(31'd7, 1'b0);
    send_price(31'd500, 1'b1);
    send_price(31'd600, 1'b0);
    write_window(7'd0);
    send_price(31'd900, 1'b0);
    write_window(7'd127);
    send_price(31'd950, 1'b0);
    write_window(7'd65);
    send_price(31'd1, 1'b0);
    write_window(7'd2);
    send_price(31'd2, 1'b0);
    send_price(31'd3, 1'b0);
    send_price(31'd4, 1'b0);
    write_window(7'd64);
    send_price(31'd5, 1'b0);
    send_price(31'h2AAAAAAA, 1'b0);
    send_price(31'h55555555, 1'b0);
    drain();

    run_phase(530, 34, 64, 1'b1);
    run_phase(530, 64, 34, 1'b0);
    run_phase(530, 0, 0, 1'b1);

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples across %0d window settings; %0d results checked, %0d mismatches",
             samples_sent, window_writes, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
